>>> rtl/multi_button_debounce_mask_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce block
// Immediate-style wrappers around concurrent properties, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_DEBOUNCE_MASK_MACROS_SVH
`define MULTI_BUTTON_DEBOUNCE_MASK_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define MBDM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MBDM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MBDM_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`define MBDM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

>>> rtl/mbdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdm_pkg
// Shared types, widths and codes of the button debounce block.
// ----------------------------------------------------------------------------
package mbdm_pkg;

    localparam int BUTTON_COUNT_DEF = 16;
    localparam int RAW_W            = 16;
    localparam int TIME_W           = 32;
    localparam int PIN_W            = 32;
    localparam int MAP_IDX_W        = 4;
    localparam int BTN_IDX_W        = 4;
    localparam int DEB_W            = 16;

    localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd20;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef enum logic [1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_SUMMARY = 2'd2
    } mbdm_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUMMARY
    } mbdm_state_t;

    typedef struct packed {
        mbdm_kind_t             kind;
        logic [BTN_IDX_W-1:0]   button_index;
        logic [PIN_W-1:0]       pin_word;
        logic                   last;
    } mbdm_event_t;

    function automatic int idx_w(input int n);
        idx_w = (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

>>> rtl/mbdm_vram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdm_vram
// Single-port-write, single-port-read RAM with registered read and
// per-entry valid bits; an entry never written reads as RST_VAL.
// ----------------------------------------------------------------------------
module mbdm_vram #(
    parameter int                  DEPTH   = 16,
    parameter int                  WIDTH   = 32,
    parameter logic [WIDTH-1:0]    RST_VAL = '0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [mbdm_pkg::idx_w(DEPTH)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                   wr_data,
    input  logic                               rd_en,
    input  logic [mbdm_pkg::idx_w(DEPTH)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                   rd_data
);
    import mbdm_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : RST_VAL;

endmodule

>>> rtl/mbdm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbdm_seq
// Scan sequencer: walks one button per cycle unless an event waits for room,
// via stamp/level and pin map RAMs; updates the pressed mask, issues events.
// ----------------------------------------------------------------------------
`include "multi_button_debounce_mask_macros.svh"

module mbdm_seq #(
    parameter int BUTTON_COUNT = mbdm_pkg::BUTTON_COUNT_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [mbdm_pkg::RAW_W-1:0]         s_raw_levels,
    input  logic [mbdm_pkg::TIME_W-1:0]        s_now_ms,
    input  logic [mbdm_pkg::MAP_IDX_W-1:0]     s_map_index,
    input  logic [mbdm_pkg::PIN_W-1:0]         s_map_pins,
    input  logic [mbdm_pkg::DEB_W-1:0]         debounce_ms,
    input  logic                               out_free,
    output logic                               ev_push,
    output mbdm_pkg::mbdm_event_t              ev
);
    import mbdm_pkg::*;

    localparam int IDX_W = idx_w(BUTTON_COUNT);
    localparam int ST_W  = TIME_W + 1;
    localparam logic [ST_W-1:0] ST_RST = {1'b1, {TIME_W{1'b0}}};
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

    mbdm_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic [RAW_W-1:0]   raw_sh_reg, raw_sh_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic               changed_reg, changed_next;
    logic [PIN_W-1:0]   mask_reg, mask_next;

    // stamp RAM word: {accepted level, start stamp}
    logic               st_wr_en, st_rd_en;
    logic [IDX_W-1:0]   st_rd_addr;
    logic [ST_W-1:0]    st_wr_data, st_rd_data;
    logic               pm_wr_en, pm_rd_en;
    logic [IDX_W-1:0]   pm_wr_addr, pm_rd_addr;
    logic [PIN_W-1:0]   pm_rd_data;

    logic               acc_lvl, lvl, mismatch, timed, fire, advance;
    logic [TIME_W-1:0]  stamp, elapsed;

    mbdm_vram #(
        .DEPTH   (BUTTON_COUNT),
        .WIDTH   (ST_W),
        .RST_VAL (ST_RST)
    ) u_stamp_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_wr_en),
        .wr_addr (eval_idx_reg),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    mbdm_vram #(
        .DEPTH   (BUTTON_COUNT),
        .WIDTH   (PIN_W),
        .RST_VAL ({PIN_W{1'b0}})
    ) u_pin_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (pm_wr_en),
        .wr_addr (pm_wr_addr),
        .wr_data (s_map_pins),
        .rd_en   (pm_rd_en),
        .rd_addr (pm_rd_addr),
        .rd_data (pm_rd_data)
    );

    assign acc_lvl  = st_rd_data[ST_W-1];
    assign stamp    = st_rd_data[TIME_W-1:0];
    assign lvl      = raw_sh_reg[0];
    assign mismatch = (acc_lvl != lvl);
    assign timed    = (stamp != '0);
    assign elapsed  = now_reg - stamp;
    assign fire     = mismatch && timed && (elapsed >= TIME_W'(debounce_ms));
    assign advance  = !fire || out_free;
    assign pm_wr_addr = IDX_W'(s_map_index);

    always_comb begin
        state_next    = state_reg;
        eval_idx_next = eval_idx_reg;
        raw_sh_next   = raw_sh_reg;
        now_next      = now_reg;
        changed_next  = changed_reg;
        mask_next     = mask_reg;
        s_ready       = 1'b0;
        st_wr_en      = 1'b0;
        st_rd_en      = 1'b0;
        st_rd_addr    = eval_idx_reg + 1'b1;
        pm_wr_en      = 1'b0;
        pm_rd_en      = 1'b0;
        pm_rd_addr    = eval_idx_reg + 1'b1;
        ev_push       = 1'b0;
        ev            = '{kind: KIND_SUMMARY, button_index: '0, pin_word: mask_reg,
                          last: 1'b1};

        if (!mismatch) begin
            st_wr_data = {acc_lvl, {TIME_W{1'b0}}};
        end else if (!timed) begin
            st_wr_data = {acc_lvl, now_reg};    // tick of zero leaves timer idle
        end else if (fire) begin
            st_wr_data = {lvl, stamp};
        end else begin
            st_wr_data = {acc_lvl, stamp};
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_SCAN) begin
                        st_rd_en      = 1'b1;
                        st_rd_addr    = '0;
                        pm_rd_en      = 1'b1;
                        pm_rd_addr    = '0;
                        eval_idx_next = '0;
                        raw_sh_next   = s_raw_levels;
                        now_next      = s_now_ms;
                        changed_next  = 1'b0;
                        state_next    = ST_SCAN;
                    end else if (int'(s_map_index) < BUTTON_COUNT) begin
                        pm_wr_en = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (advance) begin
                    st_wr_en = 1'b1;
                    if (fire) begin
                        ev_push      = 1'b1;
                        ev.kind      = lvl ? KIND_RELEASE : KIND_PRESS;
                        ev.button_index = BTN_IDX_W'(eval_idx_reg);
                        ev.pin_word  = pm_rd_data;
                        ev.last      = 1'b0;
                        mask_next    = lvl ? (mask_reg & ~pm_rd_data)
                                           : (mask_reg | pm_rd_data);
                        changed_next = 1'b1;
                    end
                    // buttons past the carried raw bits read as released
                    raw_sh_next = {1'b1, raw_sh_reg[RAW_W-1:1]};
                    if (eval_idx_reg == LAST_IDX) begin
                        state_next = (changed_reg || fire) ? ST_SUMMARY : ST_IDLE;
                    end else begin
                        st_rd_en      = 1'b1;
                        pm_rd_en      = 1'b1;
                        eval_idx_next = eval_idx_reg + 1'b1;
                    end
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    ev_push    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            eval_idx_reg <= '0;
            changed_reg  <= 1'b0;
            mask_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            eval_idx_reg <= eval_idx_next;
            changed_reg  <= changed_next;
            mask_reg     <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_sh_reg <= raw_sh_next;
        now_reg    <= now_next;
    end

    `MBDM_ASSERT_IMPLY(a_no_same_entry, aclk, aresetn, st_wr_en && st_rd_en,
        eval_idx_reg != st_rd_addr, "stamp RAM read and write hit the same entry")
    `MBDM_ASSERT_IMPLY(a_summary_needs_change, aclk, aresetn,
        ev_push && (ev.kind == KIND_SUMMARY), changed_reg,
        "summary issued for a scan without changes")
    `MBDM_ASSERT_IMPLY(a_push_needs_room, aclk, aresetn, ev_push, out_free,
        "event pushed while output register is occupied")
    `MBDM_ASSERT_NEXT(a_scan_starts_at_zero, aclk, aresetn,
        (state_reg == ST_IDLE) && (state_next == ST_SCAN),
        (eval_idx_reg == '0) && (state_reg == ST_SCAN),
        "scan did not start at the first button")

endmodule

>>> rtl/multi_button_debounce_mask.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_button_debounce_mask
// Debouncer for a bank of buttons with a virtual-pin pressed mask.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per request. A scan (s_req_type = 0) gives the
//   raw levels (0 = pressed) and the ms tick; a load (s_req_type = 1) writes the
//   pin word of button s_map_index into the pin map.
//   m_* channel: per scan, one press/release event per button that settled,
//   then a summary carrying the pressed mask with m_last high. Scans with no
//   settled button produce nothing.
//   cfg_* channel: writes debounce_ms (reset 20); write only while idle.
//   Timing: a scan is accepted, then the block walks one button per cycle
//   through the stamp RAM read port while no event waits on a stalled m_ready,
//   then issues the summary when a button settled; a load is written in its
//   accept cycle. Every event passes the output register before m_valid.
//   A stalled m_ready holds the walk at the next button that has an event;
//   one output register decouples the two sides.
//   Reset: all buttons released, no timers, mask and pin map zero; RAM valid
//   bits are cleared at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_button_debounce_mask #(
    parameter int BUTTON_COUNT = mbdm_pkg::BUTTON_COUNT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbdm_pkg::DEB_W-1:0]       cfg_debounce_ms,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [mbdm_pkg::RAW_W-1:0]       s_raw_levels,
    input  logic [mbdm_pkg::TIME_W-1:0]      s_now_ms,
    input  logic [mbdm_pkg::MAP_IDX_W-1:0]   s_map_index,
    input  logic [mbdm_pkg::PIN_W-1:0]       s_map_pins,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_event_kind,
    output logic [mbdm_pkg::BTN_IDX_W-1:0]   m_button_index,
    output logic [mbdm_pkg::PIN_W-1:0]       m_pin_word,
    output logic                             m_last
);
    import mbdm_pkg::*;

    logic [DEB_W-1:0] debounce_reg;
    logic             m_valid_reg;
    mbdm_event_t      m_ev_reg;
    logic             out_free, ev_push;
    mbdm_event_t      ev;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RST;
        end else if (cfg_valid) begin
            debounce_reg <= cfg_debounce_ms;
        end
    end

    mbdm_seq #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_raw_levels (s_raw_levels),
        .s_now_ms     (s_now_ms),
        .s_map_index  (s_map_index),
        .s_map_pins   (s_map_pins),
        .debounce_ms  (debounce_reg),
        .out_free     (out_free),
        .ev_push      (ev_push),
        .ev           (ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ev_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_push) begin
            m_ev_reg <= ev;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_kind   = m_ev_reg.kind;
    assign m_button_index = m_ev_reg.button_index;
    assign m_pin_word     = m_ev_reg.pin_word;
    assign m_last         = m_ev_reg.last;

endmodule
